>>> hdl/acf_pkg.sv
// Types and constants shared by the ANSI escape colour filter modules.
package acf_pkg;

  localparam int unsigned NUM_PARAMS  = 5;
  localparam int unsigned PARAM_IDX_W = 3;

  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_CSI_OPEN = 8'h5B;
  localparam logic [7:0] BYTE_SGR      = 8'h6D;
  localparam logic [7:0] BYTE_SEP      = 8'h3B;
  localparam logic [7:0] BYTE_DIGIT_LO = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_HI = 8'h39;
  localparam logic [7:0] FINAL_LOW     = 8'h40;
  localparam logic [7:0] FINAL_HIGH    = 8'h7E;
  localparam logic [7:0] CODE_FG       = 8'd38;
  localparam logic [7:0] CODE_RGB      = 8'd2;
  localparam logic [7:0] PARAM_MAX     = 8'd255;

  localparam logic [23:0] DEFAULT_FG = 24'h6495ED;

  typedef enum logic [2:0] {
    MODE_GROUND = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_CSI    = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    logic [7:0]  glyph_code;
    logic [23:0] glyph_colour;
  } glyph_t;

endpackage

>>> hdl/acf_parser.sv
// Escape sequence parser holding the parse state and the current foreground colour.
module acf_parser
  import acf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  text_t  text,
  output logic   result_valid,
  output glyph_t result
);

  mode_t                  mode, mode_next;
  logic [PARAM_IDX_W-1:0] param_count, param_count_next;
  logic [7:0]             param_values [NUM_PARAMS];
  logic [7:0]             param_values_next [NUM_PARAMS];
  logic                   param_malformed, param_malformed_next;
  logic [23:0]            foreground, foreground_next;

  logic [7:0]  b;
  logic [11:0] digit_sum;
  logic [7:0]  digit_sat;
  logic        is_final;
  logic        is_digit;
  logic        sgr_ok;

  assign b = text.text_byte;
  assign is_final = (b >= FINAL_LOW) && (b <= FINAL_HIGH);
  assign is_digit = (b >= BYTE_DIGIT_LO) && (b <= BYTE_DIGIT_HI);
  assign sgr_ok = !param_malformed && (param_count >= PARAM_IDX_W'(NUM_PARAMS - 1))
                  && (param_values[1] == CODE_RGB) && (param_values[0] == CODE_FG);

  always_comb begin
    logic [7:0] cur;
    cur = param_values[param_count];
    digit_sum = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {4'b0000, (b - BYTE_DIGIT_LO)};
    digit_sat = (digit_sum > {4'b0000, PARAM_MAX}) ? PARAM_MAX : digit_sum[7:0];
  end

  always_comb begin
    mode_next            = mode;
    param_count_next     = param_count;
    param_values_next    = param_values;
    param_malformed_next = param_malformed;
    foreground_next      = foreground;
    result_valid         = 1'b0;
    result.glyph_code    = b;
    result.glyph_colour  = foreground;
    unique case (mode)
      MODE_ESCAPE: begin
        if (b == BYTE_CSI_OPEN) begin
          mode_next = MODE_CSI;
        end else begin
          mode_next = MODE_GROUND;
        end
      end
      MODE_CSI: begin
        if (is_final) begin
          if ((b == BYTE_SGR) && sgr_ok) begin
            foreground_next = {param_values[2], param_values[3], param_values[4]};
          end
          mode_next            = MODE_GROUND;
          param_count_next     = '0;
          param_values_next    = '{default: '0};
          param_malformed_next = 1'b0;
        end else if (is_digit) begin
          if (param_count < PARAM_IDX_W'(NUM_PARAMS)) begin
            param_values_next[param_count] = digit_sat;
          end
        end else if (b == BYTE_SEP) begin
          if (param_count < PARAM_IDX_W'(NUM_PARAMS)) begin
            param_count_next = param_count + 1'b1;
          end
        end else begin
          param_malformed_next = 1'b1;
        end
      end
      MODE_GROUND: begin
        if (b == BYTE_ESC) begin
          mode_next = MODE_ESCAPE;
        end else begin
          result_valid = accept;
        end
      end
      default: begin
        mode_next = MODE_GROUND;
      end
    endcase
    if (text.end_of_text) begin
      mode_next            = MODE_GROUND;
      param_count_next     = '0;
      param_values_next    = '{default: '0};
      param_malformed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_GROUND;
      param_count     <= '0;
      param_values    <= '{default: '0};
      param_malformed <= 1'b0;
      foreground      <= DEFAULT_FG;
    end else if (accept) begin
      mode            <= mode_next;
      param_count     <= param_count_next;
      param_values    <= param_values_next;
      param_malformed <= param_malformed_next;
      foreground      <= foreground_next;
    end
  end

  // The parameter counter stops one past the last collected parameter.
  assert property (@(posedge clk) disable iff (rst)
    param_count <= PARAM_IDX_W'(NUM_PARAMS))
    else $error("parameter counter ran past its limit");

  // Outside a control sequence the parameter state is always clear.
  assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_CSI) |-> (param_count == '0 && !param_malformed))
    else $error("parameter state left set outside a control sequence");

  // Only plain bytes in ground produce a glyph.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (mode == MODE_GROUND && b != BYTE_ESC && accept))
    else $error("glyph produced outside ground");

endmodule

>>> hdl/acf_out_stage.sv
// Output register with a skid stage for the glyph channel.
module acf_out_stage
  import acf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   result_valid,
  input  glyph_t result,
  output logic   skid_full,
  output logic   glyph_valid,
  input  logic   glyph_stall,
  output glyph_t glyph
);

  logic   out_valid;
  glyph_t out_data;
  logic   skid_valid;
  glyph_t skid_data;

  assign glyph_valid = out_valid;
  assign glyph       = out_data;
  assign skid_full   = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !glyph_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= result_valid;
      end
    end else if (result_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !glyph_stall) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (result_valid) begin
      skid_data <= result;
    end
  end

  // The skid stage only ever holds a request behind a waiting one.
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  // No new request arrives while the skid stage is occupied.
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !result_valid)
    else $error("request arrived while skid stage full");

  // A drained output register is refilled from the skid stage.
  assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !glyph_stall) |=> (out_valid && !skid_valid))
    else $error("skid stage did not move up");

endmodule

>>> hdl/ansi_csi_colour_filter.sv
// Top level of the ANSI escape stripping filter with foreground colour tracking.
// It takes one text byte per cycle unless stalled, strips escape sequences and passes
// every other byte on with the 24-bit foreground colour in force; an SGR sequence
// 38;2;R;G;B sets that colour. Each request is parsed in the cycle it is accepted and
// its glyph, if any, registered at the output, or in the one-entry skid stage on a
// glyph stall. The output sustains one byte per cycle while glyph_stall is low;
// text_stall rises only while the skid stage holds a glyph, after a stall with two
// glyphs outstanding. After reset the foreground colour is 0x6495ED.
module ansi_csi_colour_filter
  import acf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   text_valid,
  output logic   text_stall,
  input  text_t  text,
  output logic   glyph_valid,
  input  logic   glyph_stall,
  output glyph_t glyph
);

  logic   accept;
  logic   result_valid;
  glyph_t result;
  logic   skid_full;

  assign text_stall = skid_full;
  assign accept     = text_valid && !skid_full;

  acf_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .text         (text),
    .result_valid (result_valid),
    .result       (result)
  );

  acf_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .result_valid (result_valid),
    .result       (result),
    .skid_full    (skid_full),
    .glyph_valid  (glyph_valid),
    .glyph_stall  (glyph_stall),
    .glyph        (glyph)
  );

endmodule

>>> test/tb_ansi_csi_colour_filter.sv
// Self-checking testbench for the ANSI escape colour filter with a byte-level predictor.
`timescale 1ns / 100ps

module tb_ansi_csi_colour_filter;
  import acf_pkg::*;

  localparam logic [7:0] CODE_BG = 8'd48;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 450;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   text_valid = 1'b0;
  logic   text_stall;
  text_t  text_req = '0;
  logic   glyph_valid;
  logic   glyph_stall = 1'b0;
  glyph_t glyph;

  text_t      pending[$];
  glyph_t     glyphs_due[$];
  logic [7:0] unit_bytes[$];

  int queued_count = 0;
  int accepted_count = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  mode_t       parser_mode;
  logic [2:0]  param_idx;
  logic [7:0]  param_val [NUM_PARAMS];
  logic        param_bad;
  logic [23:0] colour_now;

  ansi_csi_colour_filter u_dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text_req),
    .glyph_valid (glyph_valid),
    .glyph_stall (glyph_stall),
    .glyph       (glyph)
  );

  always #1 clk = ~clk;

  task automatic clear_params();
    param_idx = '0;
    for (int i = 0; i < NUM_PARAMS; i++) param_val[i] = '0;
    param_bad = 1'b0;
  endtask

  task automatic filter_request(input text_t req);
    logic [7:0] b;
    int         v;
    glyph_t     g;
    b = req.text_byte;
    case (parser_mode)
      MODE_ESCAPE: begin
        if (b == BYTE_CSI_OPEN) begin
          parser_mode = MODE_CSI;
          clear_params();
        end else begin
          parser_mode = MODE_GROUND;
        end
      end
      MODE_CSI: begin
        if (b >= FINAL_LOW && b <= FINAL_HIGH) begin
          if (b == BYTE_SGR && !param_bad && param_idx >= NUM_PARAMS - 1 &&
              param_val[1] == CODE_RGB && param_val[0] == CODE_FG) begin
            colour_now = {param_val[2], param_val[3], param_val[4]};
          end
          parser_mode = MODE_GROUND;
          clear_params();
        end else if (b >= BYTE_DIGIT_LO && b <= BYTE_DIGIT_HI) begin
          if (param_idx < NUM_PARAMS) begin
            v = int'(param_val[param_idx]) * 10 + int'(b) - int'(BYTE_DIGIT_LO);
            param_val[param_idx] = (v > int'(PARAM_MAX)) ? PARAM_MAX : v[7:0];
          end
        end else if (b == BYTE_SEP) begin
          if (param_idx < NUM_PARAMS) param_idx = param_idx + 3'd1;
        end else begin
          param_bad = 1'b1;
        end
      end
      default: begin
        parser_mode = MODE_GROUND;
        if (b == BYTE_ESC) begin
          parser_mode = MODE_ESCAPE;
        end else begin
          g.glyph_code   = b;
          g.glyph_colour = colour_now;
          glyphs_due.insert(glyphs_due.size(), g);
        end
      end
    endcase
    if (req.end_of_text) begin
      parser_mode = MODE_GROUND;
      clear_params();
    end
  endtask

  task automatic put(input logic [7:0] b);
    unit_bytes.insert(unit_bytes.size(), b);
  endtask

  // A negative value leaves the parameter empty.
  task automatic put_number(input int v);
    string s;
    if (v >= 0) begin
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) put(s[i]);
    end
  endtask

  task automatic emit_unit(input int eot_at);
    text_t r;
    for (int i = 0; i < unit_bytes.size(); i++) begin
      r.text_byte   = unit_bytes[i];
      r.end_of_text = (i == eot_at);
      pending.insert(pending.size(), r);
      queued_count++;
    end
    unit_bytes.delete();
  endtask

  task automatic put_sgr();
    int         nparams;
    int         sel;
    int         v;
    logic [7:0] junk;
    put(BYTE_ESC);
    put(BYTE_CSI_OPEN);
    nparams = ($urandom_range(0, 99) < 75) ? NUM_PARAMS : $urandom_range(0, 8);
    for (int k = 0; k < nparams; k++) begin
      if (k > 0) put(BYTE_SEP);
      sel = $urandom_range(0, 99);
      if (k == 0) begin
        v = (sel < 60) ? CODE_FG : (sel < 80) ? CODE_BG : $urandom_range(0, 300);
      end else if (k == 1) begin
        v = (sel < 85) ? CODE_RGB : $urandom_range(0, 12);
      end else if (sel < 75) begin
        v = $urandom_range(0, 255);
      end else if (sel < 85) begin
        v = -1;
      end else begin
        v = $urandom_range(256, 99999);
      end
      put_number(v);
    end
    if ($urandom_range(0, 99) < 12) begin
      if ($urandom_range(0, 3) == 0) begin
        junk = BYTE_ESC;
      end else begin
        do junk = 8'($urandom_range(0, 255)); while (junk >= FINAL_LOW && junk <= FINAL_HIGH);
      end
      unit_bytes.insert($urandom_range(2, unit_bytes.size()), junk);
    end
    if ($urandom_range(0, 99) < 85) put(BYTE_SGR);
    else put(8'($urandom_range(FINAL_LOW, FINAL_HIGH)));
  endtask

  task automatic add_random_unit();
    int sel;
    int eot_pct;
    sel = $urandom_range(0, 99);
    eot_pct = 10;
    if (sel < 55) begin
      put_sgr();
    end else if (sel < 75) begin
      repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
    end else if (sel < 85) begin
      put(BYTE_ESC);
      put(8'($urandom_range(0, 255)));
    end else if (sel < 93) begin
      put(BYTE_ESC);
      put(BYTE_CSI_OPEN);
      repeat ($urandom_range(0, 6)) put(8'($urandom_range(8'h20, 8'h3F)));
      put(8'($urandom_range(FINAL_LOW, FINAL_HIGH)));
    end else begin
      put(8'($urandom_range(0, 255)));
      eot_pct = 50;
    end
    emit_unit(($urandom_range(0, 99) < eot_pct) ?
              int'($urandom_range(0, unit_bytes.size() - 1)) : -1);
  endtask

  task automatic fill_phase();
    int target;
    target = queued_count + PHASE_ITEMS;
    while (queued_count < target) add_random_unit();
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || glyphs_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
      text_req   <= '0;
    end else begin
      if (text_valid && !text_stall) begin
        filter_request(text_req);
        accepted_count++;
      end
      if (!text_valid || !text_stall) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          text_req   <= pending.pop_front();
          text_valid <= 1'b1;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : glyph_monitor
    glyph_t want;
    if (rst) begin
      glyph_stall <= 1'b0;
    end else begin
      if (glyph_valid && !glyph_stall) begin
        if (glyphs_due.size() == 0) begin
          $display("%0t: unexpected glyph code %h colour %h", $time,
                   glyph.glyph_code, glyph.glyph_colour);
          mismatches++;
        end else begin
          want = glyphs_due.pop_front();
          if (glyph.glyph_code !== want.glyph_code) begin
            $display("%0t: glyph_code expected %h actual %h", $time,
                     want.glyph_code, glyph.glyph_code);
            mismatches++;
          end
          if (glyph.glyph_colour !== want.glyph_colour) begin
            $display("%0t: glyph_colour expected %h actual %h", $time,
                     want.glyph_colour, glyph.glyph_colour);
            mismatches++;
          end
        end
      end
      glyph_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d glyphs outstanding", $time, glyphs_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    parser_mode = MODE_GROUND;
    clear_params();
    colour_now = DEFAULT_FG;

    send_idle_pct  = 25;
    recv_stall_pct = 84;

    // Plain bytes, control and high bytes, and an escape that carries the end of text.
    put(8'h41);
    put(8'h00);
    put(8'hFF);
    emit_unit(-1);
    put(BYTE_ESC);
    emit_unit(0);
    put(8'h7F);
    put(BYTE_ESC);
    put(8'h78);
    // Saturating channel and an empty channel in one colour change.
    put(BYTE_ESC);
    put(BYTE_CSI_OPEN);
    put_number(int'(CODE_FG));
    put(BYTE_SEP);
    put_number(int'(CODE_RGB));
    put(BYTE_SEP);
    put_number(300);
    put(BYTE_SEP);
    put(BYTE_SEP);
    put_number(9);
    put(BYTE_SGR);
    put(8'h61);
    // A control sequence with another final byte, then a byte that ends the text.
    put(BYTE_ESC);
    put(BYTE_CSI_OPEN);
    put(8'h35);
    put(8'h48);
    put(8'h62);
    emit_unit(unit_bytes.size() - 1);

    fill_phase();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait_drained();
    send_idle_pct  = 84;
    recv_stall_pct = 25;
    fill_phase();

    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fill_phase();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (glyphs_due.size() != 0) begin
      $display("%0t: %0d expected glyphs never arrived", $time, glyphs_due.size());
      mismatches += glyphs_due.size();
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/acf_pkg.sv
hdl/acf_parser.sv
hdl/acf_out_stage.sv
hdl/ansi_csi_colour_filter.sv
test/tb_ansi_csi_colour_filter.sv
